/* hw/rtl/attupd_pkg.sv */
// package: widths, reset values, codes and the micro-op table of the attitude update
`timescale 1ns / 1ps
package attupd_pkg;

  localparam int FRAC_BITS = 28;
  localparam int VEC_W     = 32;
  localparam int POS_W     = 48;
  localparam int SPD_W     = 31;
  localparam int OPD_W     = VEC_W + 1;
  localparam int PROD_W    = 2 * OPD_W;
  localparam int ACC_W     = PROD_W - FRAC_BITS + 2;
  localparam int MOVE_W    = POS_W + 1;
  localparam int DIV_W     = VEC_W + FRAC_BITS;
  localparam int SQ_W      = VEC_W - 1 + FRAC_BITS;
  localparam int SQ_STEPS  = (SQ_W + 1) / 2;
  localparam int CNT_W     = $clog2(DIV_W + 1);
  localparam int PC_W      = 5;
  localparam int ROT_W     = 4;
  localparam int REG_ADDR_W = 5;
  localparam int APB_W     = 32;

  localparam longint Q30_SPEED = 1073741;
  localparam longint Q30_COS   = 1073258676;
  localparam longint Q30_SIN   = 32207424;
  localparam longint ONE_L     = longint'(1) << FRAC_BITS;

  localparam logic [SPD_W-1:0]        RST_SPEED = SPD_W'(Q30_SPEED >> (30 - FRAC_BITS));
  localparam logic signed [VEC_W-1:0] RST_COS   = VEC_W'(Q30_COS >> (30 - FRAC_BITS));
  localparam logic signed [VEC_W-1:0] RST_SIN   = VEC_W'(Q30_SIN >> (30 - FRAC_BITS));
  localparam logic signed [VEC_W-1:0] ONE_Q     = VEC_W'(ONE_L);
  localparam logic signed [POS_W-1:0] POS_Z0    = POS_W'((ONE_L + 5) / 10);
  localparam logic [SQ_W-1:0]         SQ_BIT0   = SQ_W'(longint'(1) << (2 * (SQ_STEPS - 1)));
  localparam logic [ROT_W-1:0]        ROT_DONE  = ROT_W'(8);

  localparam logic signed [VEC_W-1:0] S32_MAX = {1'b0, {(VEC_W-1){1'b1}}};
  localparam logic signed [VEC_W-1:0] S32_MIN = {1'b1, {(VEC_W-1){1'b0}}};
  localparam logic signed [POS_W-1:0] S48_MAX = {1'b0, {(POS_W-1){1'b1}}};
  localparam logic signed [POS_W-1:0] S48_MIN = {1'b1, {(POS_W-1){1'b0}}};

  typedef enum logic [2:0] {
    REG_SPEED, REG_ROLL_COS, REG_ROLL_SIN, REG_PITCH_COS, REG_PITCH_SIN
  } reg_e;

  typedef enum logic [3:0] {
    OPD_UI, OPD_UJ, OPD_UK, OPD_PI, OPD_PJ, OPD_PK, OPD_SS, OPD_SP,
    OPD_DOT, OPD_PERP, OPD_CR, OPD_LEN, OPD_LC, OPD_CS, OPD_SN
  } opnd_e;

  typedef enum logic [2:0] {
    DST_L2, DST_DOT, DST_SS, DST_SP, DST_PERP, DST_CR, DST_LC, DST_NUM
  } dst_e;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SETUP, ST_MUL, ST_ACC, ST_SQRT, ST_DIV, ST_QUOT, ST_WRITE,
    ST_MOVE_MUL, ST_MOVE_ACC, ST_OUT
  } state_e;

  typedef struct packed {
    opnd_e a;
    opnd_e b;
    logic  first;
    logic  last;
    logic  sub;
    dst_e  dst;
  } uop_t;

  localparam logic [PC_W-1:0] UOP_L2_LAST  = PC_W'(2);
  localparam logic [PC_W-1:0] UOP_LOOP     = PC_W'(6);
  localparam logic [PC_W-1:0] UOP_NUM_LAST = PC_W'(17);

  function automatic uop_t uop_at(logic [PC_W-1:0] pc);
    uop_t u;
    u = '{a: OPD_UI, b: OPD_UI, first: 1'b1, last: 1'b0, sub: 1'b0, dst: DST_L2};
    case (pc)
      5'd0:  u = '{OPD_UI,   OPD_UI,  1'b1, 1'b0, 1'b0, DST_L2};
      5'd1:  u = '{OPD_UJ,   OPD_UJ,  1'b0, 1'b0, 1'b0, DST_L2};
      5'd2:  u = '{OPD_UK,   OPD_UK,  1'b0, 1'b1, 1'b0, DST_L2};
      5'd3:  u = '{OPD_UI,   OPD_PI,  1'b1, 1'b0, 1'b0, DST_DOT};
      5'd4:  u = '{OPD_UJ,   OPD_PJ,  1'b0, 1'b0, 1'b0, DST_DOT};
      5'd5:  u = '{OPD_UK,   OPD_PK,  1'b0, 1'b1, 1'b0, DST_DOT};
      5'd6:  u = '{OPD_UJ,   OPD_UJ,  1'b1, 1'b0, 1'b0, DST_SS};
      5'd7:  u = '{OPD_UK,   OPD_UK,  1'b0, 1'b1, 1'b0, DST_SS};
      5'd8:  u = '{OPD_UJ,   OPD_PJ,  1'b1, 1'b0, 1'b0, DST_SP};
      5'd9:  u = '{OPD_UK,   OPD_PK,  1'b0, 1'b1, 1'b0, DST_SP};
      5'd10: u = '{OPD_PI,   OPD_SS,  1'b1, 1'b0, 1'b0, DST_PERP};
      5'd11: u = '{OPD_UI,   OPD_SP,  1'b0, 1'b1, 1'b1, DST_PERP};
      5'd12: u = '{OPD_UJ,   OPD_PK,  1'b1, 1'b0, 1'b0, DST_CR};
      5'd13: u = '{OPD_UK,   OPD_PJ,  1'b0, 1'b1, 1'b1, DST_CR};
      5'd14: u = '{OPD_LEN,  OPD_CR,  1'b1, 1'b1, 1'b0, DST_LC};
      5'd15: u = '{OPD_UI,   OPD_DOT, 1'b1, 1'b0, 1'b0, DST_NUM};
      5'd16: u = '{OPD_PERP, OPD_CS,  1'b0, 1'b0, 1'b0, DST_NUM};
      5'd17: u = '{OPD_LC,   OPD_SN,  1'b0, 1'b1, 1'b0, DST_NUM};
      default: u = '{OPD_UI, OPD_UI,  1'b1, 1'b0, 1'b0, DST_L2};
    endcase
    return u;
  endfunction

  function automatic logic signed [VEC_W-1:0] sat32(logic signed [ACC_W-1:0] v);
    if (v > ACC_W'(S32_MAX)) return S32_MAX;
    if (v < ACC_W'(S32_MIN)) return S32_MIN;
    return v[VEC_W-1:0];
  endfunction

  function automatic logic signed [POS_W-1:0] sat48(logic signed [MOVE_W-1:0] v);
    if (v > MOVE_W'(S48_MAX)) return S48_MAX;
    if (v < MOVE_W'(S48_MIN)) return S48_MIN;
    return v[POS_W-1:0];
  endfunction

endpackage

/* hw/rtl/attupd_if.sv */
// valid/ready channels for the control tick and the pose
`timescale 1ns / 1ps
interface attupd_in_if;
  logic valid;
  logic ready;
  logic pitch_down_held;
  logic roll_left_held;
  logic pitch_up_held;
  logic roll_right_held;
  modport source (output valid, pitch_down_held, roll_left_held, pitch_up_held,
                  roll_right_held, input ready);
  modport sink (input valid, pitch_down_held, roll_left_held, pitch_up_held,
                roll_right_held, output ready);
endinterface

interface attupd_out_if;
  logic valid;
  logic ready;
  logic signed [attupd_pkg::POS_W-1:0] position_x;
  logic signed [attupd_pkg::POS_W-1:0] position_y;
  logic signed [attupd_pkg::POS_W-1:0] position_z;
  logic signed [attupd_pkg::VEC_W-1:0] forward_x;
  logic signed [attupd_pkg::VEC_W-1:0] forward_y;
  logic signed [attupd_pkg::VEC_W-1:0] forward_z;
  logic signed [attupd_pkg::VEC_W-1:0] upward_x;
  logic signed [attupd_pkg::VEC_W-1:0] upward_y;
  logic signed [attupd_pkg::VEC_W-1:0] upward_z;
  modport source (output valid, position_x, position_y, position_z, forward_x, forward_y,
                  forward_z, upward_x, upward_y, upward_z, input ready);
  modport sink (input valid, position_x, position_y, position_z, forward_x, forward_y,
                forward_z, upward_x, upward_y, upward_z, output ready);
endinterface

/* hw/rtl/axis_angle_attitude_update.sv */
// Attitude update: one tick rotates the forward, up and wing vectors by the held pitch and
// roll controls (pitch down, roll left, pitch up, roll right, two rotations each) with the
// general Rodrigues formula, then moves the position by speed times forward and emits the
// pose word. All arithmetic runs on one shared 33x33 multiplier with an accumulator, a
// bit-serial square root and a restoring divider that makes one quotient bit a cycle. Every
// applied rotation runs 42 multiply-accumulate ops, a square root and three divides; a
// rotation whose axis has zero length stops after the squared length and leaves its vector
// as it is. The block takes a new tick only when idle; a finished pose waits in the output
// register while the next tick is taken.
`timescale 1ns / 1ps
module axis_angle_attitude_update (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  attupd_in_if.sink                          tick_i,
  attupd_out_if.source                       pose_o,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [attupd_pkg::REG_ADDR_W-1:0]  paddr,
  input  logic [attupd_pkg::APB_W-1:0]       pwdata,
  output logic [attupd_pkg::APB_W-1:0]       prdata,
  output logic                               pready
);
  import attupd_pkg::*;

  // configuration
  logic [SPD_W-1:0]        speed_q;
  logic signed [VEC_W-1:0] roll_cos_q, roll_sin_q, pitch_cos_q, pitch_sin_q;
  reg_e                    reg_idx;
  logic                    wr_en;

  // pose state
  logic signed [VEC_W-1:0] fwd_q [3];
  logic signed [VEC_W-1:0] up_q [3];
  logic signed [VEC_W-1:0] wing_q [3];
  logic signed [POS_W-1:0] pos_q [3];

  // control
  state_e           state_q, state_d;
  logic [3:0]       flags_q;
  logic [ROT_W-1:0] rot_q;
  logic [1:0]       i_q, j_idx, k_idx, mi_q;
  logic [PC_W-1:0]  pc_q;
  logic [CNT_W-1:0] cnt_q;
  logic             out_valid_q;
  logic             out_go;
  logic             rot_roll;

  // datapath
  logic signed [VEC_W-1:0]  u_q [3];
  logic signed [VEC_W-1:0]  p_q [3];
  logic signed [VEC_W-1:0]  res_q [3];
  logic signed [OPD_W-1:0]  cs_q, sn_q;
  logic signed [VEC_W-1:0]  l2_q, len_q, dot_q, ss_q, sp_q, perp_q, cr_q, lc_q;
  logic signed [PROD_W-1:0] prod_q;
  logic signed [ACC_W-1:0]  acc_q, acc_d, acc_base, prod_sh;
  logic signed [VEC_W-1:0]  acc_sat;
  logic signed [MOVE_W-1:0] move_sum;
  logic signed [OPD_W-1:0]  opa, opb, sin_ext;
  uop_t                     uop;
  logic [SQ_W-1:0]          rad_q, sq_res_q, sq_bit_q;
  logic [SQ_W:0]            sq_sum;
  logic [DIV_W-1:0]         dvd_q;
  logic [VEC_W-1:0]         rem_q, trial, num_mag;
  logic                     neg_q, div_ge;
  logic signed [VEC_W-1:0]  quot;

  // pose word
  logic signed [POS_W-1:0] opos_q [3];
  logic signed [VEC_W-1:0] ofwd_q [3];
  logic signed [VEC_W-1:0] oup_q [3];

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = reg_e'(paddr[REG_ADDR_W-1:2]);

  always_comb begin
    case (reg_idx)
      REG_SPEED:     prdata = APB_W'(speed_q);
      REG_ROLL_COS:  prdata = roll_cos_q;
      REG_ROLL_SIN:  prdata = roll_sin_q;
      REG_PITCH_COS: prdata = pitch_cos_q;
      REG_PITCH_SIN: prdata = pitch_sin_q;
      default:       prdata = '0;
    endcase
  end

  assign tick_i.ready = (state_q == ST_IDLE);
  assign pose_o.valid = out_valid_q;
  assign pose_o.position_x = opos_q[0];
  assign pose_o.position_y = opos_q[1];
  assign pose_o.position_z = opos_q[2];
  assign pose_o.forward_x  = ofwd_q[0];
  assign pose_o.forward_y  = ofwd_q[1];
  assign pose_o.forward_z  = ofwd_q[2];
  assign pose_o.upward_x   = oup_q[0];
  assign pose_o.upward_y   = oup_q[1];
  assign pose_o.upward_z   = oup_q[2];

  // flag order is pitch down, roll left, pitch up, roll right; two rotations per flag
  assign rot_roll = rot_q[1];
  assign out_go   = !out_valid_q || pose_o.ready;
  assign j_idx    = (i_q == 2'd2) ? 2'd0 : i_q + 2'd1;
  assign k_idx    = (i_q == 2'd0) ? 2'd2 : i_q - 2'd1;
  assign uop      = uop_at(pc_q);

  function automatic logic signed [OPD_W-1:0] opnd_val(opnd_e s);
    case (s)
      OPD_UI:   return OPD_W'(u_q[i_q]);
      OPD_UJ:   return OPD_W'(u_q[j_idx]);
      OPD_UK:   return OPD_W'(u_q[k_idx]);
      OPD_PI:   return OPD_W'(p_q[i_q]);
      OPD_PJ:   return OPD_W'(p_q[j_idx]);
      OPD_PK:   return OPD_W'(p_q[k_idx]);
      OPD_SS:   return OPD_W'(ss_q);
      OPD_SP:   return OPD_W'(sp_q);
      OPD_DOT:  return OPD_W'(dot_q);
      OPD_PERP: return OPD_W'(perp_q);
      OPD_CR:   return OPD_W'(cr_q);
      OPD_LEN:  return OPD_W'(len_q);
      OPD_LC:   return OPD_W'(lc_q);
      OPD_CS:   return cs_q;
      OPD_SN:   return sn_q;
      default:  return '0;
    endcase
  endfunction

  always_comb begin
    opa      = opnd_val(uop.a);
    opb      = opnd_val(uop.b);
    prod_sh  = ACC_W'(prod_q >>> FRAC_BITS);
    acc_base = uop.first ? '0 : acc_q;
    acc_d    = uop.sub ? acc_base - prod_sh : acc_base + prod_sh;
    acc_sat  = sat32(acc_d);
    move_sum = MOVE_W'(pos_q[mi_q]) + MOVE_W'(prod_sh);
    sin_ext  = rot_roll ? OPD_W'(roll_sin_q) : OPD_W'(pitch_sin_q);
    num_mag  = acc_sat[VEC_W-1] ? VEC_W'(~acc_sat + 1'b1) : VEC_W'(acc_sat);
    sq_sum   = (SQ_W+1)'(sq_res_q) + (SQ_W+1)'(sq_bit_q);
    trial    = {rem_q[VEC_W-2:0], dvd_q[DIV_W-1]};
    div_ge   = (trial >= VEC_W'(l2_q));
    if (neg_q) begin
      quot = (dvd_q > DIV_W'({1'b0, S32_MIN})) ? S32_MIN : -VEC_W'(dvd_q);
    end else begin
      quot = (dvd_q > DIV_W'(S32_MAX)) ? S32_MAX : VEC_W'(dvd_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (tick_i.valid) state_d = ST_SETUP;
      ST_SETUP: begin
        if (rot_q == ROT_DONE) state_d = ST_MOVE_MUL;
        else if (flags_q[rot_q[2:1]]) state_d = ST_MUL;
      end
      ST_MUL:   state_d = ST_ACC;
      ST_ACC: begin
        if (pc_q == UOP_L2_LAST) state_d = (acc_sat <= 0) ? ST_SETUP : ST_SQRT;
        else if (pc_q == UOP_NUM_LAST) state_d = ST_DIV;
        else state_d = ST_MUL;
      end
      ST_SQRT:  if (sq_bit_q == '0) state_d = ST_MUL;
      ST_DIV:   if (cnt_q == CNT_W'(DIV_W - 1)) state_d = ST_QUOT;
      ST_QUOT:  state_d = (i_q == 2'd2) ? ST_WRITE : ST_MUL;
      ST_WRITE: state_d = ST_SETUP;
      ST_MOVE_MUL: state_d = ST_MOVE_ACC;
      ST_MOVE_ACC: state_d = (mi_q == 2'd2) ? ST_OUT : ST_MOVE_MUL;
      ST_OUT:   if (out_go) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      speed_q     <= RST_SPEED;
      roll_cos_q  <= RST_COS;
      roll_sin_q  <= RST_SIN;
      pitch_cos_q <= RST_COS;
      pitch_sin_q <= RST_SIN;
      fwd_q       <= '{ONE_Q, '0, '0};
      up_q        <= '{'0, '0, ONE_Q};
      wing_q      <= '{'0, ONE_Q, '0};
      pos_q       <= '{'0, '0, POS_Z0};
      flags_q     <= '0;
      rot_q       <= '0;
      i_q         <= '0;
      mi_q        <= '0;
      pc_q        <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (wr_en) begin
        case (reg_idx)
          REG_SPEED:     speed_q     <= pwdata[SPD_W-1:0];
          REG_ROLL_COS:  roll_cos_q  <= pwdata;
          REG_ROLL_SIN:  roll_sin_q  <= pwdata;
          REG_PITCH_COS: pitch_cos_q <= pwdata;
          REG_PITCH_SIN: pitch_sin_q <= pwdata;
          default: ;
        endcase
      end
      if (pose_o.valid && pose_o.ready && state_q != ST_OUT) out_valid_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (tick_i.valid) begin
            flags_q <= {tick_i.roll_right_held, tick_i.pitch_up_held,
                        tick_i.roll_left_held, tick_i.pitch_down_held};
            rot_q   <= '0;
          end
        end
        ST_SETUP: begin
          if (rot_q == ROT_DONE) begin
            mi_q <= '0;
          end else if (flags_q[rot_q[2:1]]) begin
            i_q  <= '0;
            pc_q <= '0;
          end else begin
            rot_q <= rot_q + 1'b1;
          end
        end
        ST_ACC: begin
          if (pc_q != UOP_NUM_LAST) pc_q <= pc_q + 1'b1;
          if (pc_q == UOP_NUM_LAST) cnt_q <= '0;
          // zero-length axis leaves the vector as it is
          if (pc_q == UOP_L2_LAST && acc_sat <= 0) rot_q <= rot_q + 1'b1;
        end
        ST_DIV:  cnt_q <= cnt_q + 1'b1;
        ST_QUOT: begin
          if (i_q != 2'd2) begin
            i_q  <= i_q + 2'd1;
            pc_q <= UOP_LOOP;
          end
        end
        ST_WRITE: begin
          if (!rot_q[0]) up_q <= res_q;
          else if (rot_roll) wing_q <= res_q;
          else fwd_q <= res_q;
          rot_q <= rot_q + 1'b1;
        end
        ST_MOVE_ACC: begin
          pos_q[mi_q] <= sat48(move_sum);
          mi_q        <= mi_q + 2'd1;
        end
        ST_OUT: if (out_go) out_valid_q <= 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_SETUP: begin
        u_q  <= rot_roll ? fwd_q : wing_q;
        p_q  <= !rot_q[0] ? up_q : (rot_roll ? wing_q : fwd_q);
        cs_q <= rot_roll ? OPD_W'(roll_cos_q) : OPD_W'(pitch_cos_q);
        sn_q <= rot_q[2] ? sin_ext : -sin_ext;
      end
      ST_MUL: prod_q <= PROD_W'(opa) * PROD_W'(opb);
      ST_ACC: begin
        acc_q <= acc_d;
        if (uop.last) begin
          case (uop.dst)
            DST_L2:   l2_q   <= acc_sat;
            DST_DOT:  dot_q  <= acc_sat;
            DST_SS:   ss_q   <= acc_sat;
            DST_SP:   sp_q   <= acc_sat;
            DST_PERP: perp_q <= acc_sat;
            DST_CR:   cr_q   <= acc_sat;
            DST_LC:   lc_q   <= acc_sat;
            default: ;
          endcase
        end
        if (pc_q == UOP_L2_LAST) begin
          rad_q    <= {acc_sat[VEC_W-2:0], {FRAC_BITS{1'b0}}};
          sq_res_q <= '0;
          sq_bit_q <= SQ_BIT0;
        end
        if (pc_q == UOP_NUM_LAST) begin
          neg_q <= acc_sat[VEC_W-1];
          dvd_q <= {num_mag, {FRAC_BITS{1'b0}}};
          rem_q <= '0;
        end
      end
      ST_SQRT: begin
        if (sq_bit_q != '0) begin
          if ((SQ_W+1)'(rad_q) >= sq_sum) begin
            rad_q    <= SQ_W'((SQ_W+1)'(rad_q) - sq_sum);
            sq_res_q <= (sq_res_q >> 1) + sq_bit_q;
          end else begin
            sq_res_q <= sq_res_q >> 1;
          end
          sq_bit_q <= sq_bit_q >> 2;
        end else begin
          len_q <= VEC_W'(sq_res_q);
        end
      end
      ST_DIV: begin
        rem_q <= div_ge ? trial - VEC_W'(l2_q) : trial;
        dvd_q <= {dvd_q[DIV_W-2:0], div_ge};
      end
      ST_QUOT: res_q[i_q] <= quot;
      ST_MOVE_MUL: prod_q <= PROD_W'(OPD_W'({2'b00, speed_q})) * PROD_W'(fwd_q[mi_q]);
      ST_OUT: begin
        if (out_go) begin
          opos_q <= pos_q;
          ofwd_q <= fwd_q;
          oup_q  <= up_q;
        end
      end
      default: ;
    endcase
  end

  a_tick_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tick_i.valid && tick_i.ready |=> state_q == ST_SETUP)
    else $error("accepted tick did not start the sequencer");

  a_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DIV |-> l2_q > 0)
    else $error("divide by non-positive squared axis length");

  a_rot_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rot_q <= ROT_DONE)
    else $error("rotation counter out of range");

  a_out_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_OUT && out_go |=> pose_o.valid)
    else $error("finished pose not presented");

endmodule
